/* rtl/core/tkst_pkg.sv */
// shared types and constants for the top-k score table
package tkst_pkg;

   localparam int SCORE_PORT_BITS = 16;
   localparam int NAME_LOW_BITS   = 64;
   localparam int NAME_HIGH_BITS  = 32;
   localparam int RANK_BITS       = 3;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;
   localparam int QUEUE_FILL_BITS = 2;

   // one submitted entry after the front end
   typedef struct packed {
      logic [SCORE_PORT_BITS-1:0] score;
      logic [NAME_LOW_BITS-1:0]   name_low;
      logic [NAME_HIGH_BITS-1:0]  name_high;
   } item_type;

   // head of the queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   // one row of a table listing
   typedef struct packed {
      logic [RANK_BITS-1:0]       rank;
      logic [SCORE_PORT_BITS-1:0] entry_score;
      logic [NAME_LOW_BITS-1:0]   entry_name_low;
      logic [NAME_HIGH_BITS-1:0]  entry_name_high;
      logic                       accepted;
      logic                       is_new;
      logic                       last;
   } row_type;

endpackage

/* rtl/core/tkst_if.sv */
// handshake channel interfaces for submits and listing rows
interface tkst_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [tkst_pkg::SCORE_PORT_BITS-1:0] new_score;
   logic [tkst_pkg::NAME_LOW_BITS-1:0]   new_name_low;
   logic [tkst_pkg::NAME_HIGH_BITS-1:0]  new_name_high;

   modport source (output valid, new_score, new_name_low, new_name_high, input ready);
   modport sink (input valid, new_score, new_name_low, new_name_high, output ready);
endinterface

interface tkst_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [tkst_pkg::RANK_BITS-1:0]       rank;
   logic [tkst_pkg::SCORE_PORT_BITS-1:0] entry_score;
   logic [tkst_pkg::NAME_LOW_BITS-1:0]   entry_name_low;
   logic [tkst_pkg::NAME_HIGH_BITS-1:0]  entry_name_high;
   logic                                 accepted;
   logic                                 is_new;
   logic                                 last;

   modport source (output valid, rank, entry_score, entry_name_low, entry_name_high,
                   accepted, is_new, last, input ready);
   modport sink (input valid, rank, entry_score, entry_name_low, entry_name_high,
                 accepted, is_new, last, output ready);
endinterface

/* rtl/core/tkst_front.sv */
// front end: takes submit beats, trims the score and queues them for the table
module tkst_front #(
   parameter int SCORE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   tkst_req_if.sink            req_chan,
   output tkst_pkg::queue_type q_out,
   input  logic                q_pop
);

   localparam int SCORE_W = (SCORE_BITS < tkst_pkg::SCORE_PORT_BITS) ?
                            SCORE_BITS : tkst_pkg::SCORE_PORT_BITS;

   tkst_pkg::item_type                       slot_ff [tkst_pkg::QUEUE_DEPTH];
   logic [tkst_pkg::QUEUE_PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tkst_pkg::QUEUE_PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tkst_pkg::QUEUE_FILL_BITS-1:0]     fill_ff, fill_in;
   tkst_pkg::item_type                       trimmed;
   logic                                     push;

   // only the low score bits count
   always_comb begin
      trimmed.score     = tkst_pkg::SCORE_PORT_BITS'(req_chan.new_score[SCORE_W-1:0]);
      trimmed.name_low  = req_chan.new_name_low;
      trimmed.name_high = req_chan.new_name_high;
   end

   assign req_chan.ready = (fill_ff != tkst_pkg::QUEUE_FILL_BITS'(tkst_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= trimmed;
      end
   end

   assign q_out.valid = (fill_ff != '0);
   assign q_out.item  = slot_ff[rd_ptr_ff];

endmodule

/* rtl/core/tkst_back.sv */
// back end: sorted insertion into the table and row-by-row listing
module tkst_back #(
   parameter int TABLE_ENTRIES = 5,
   parameter int SCORE_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  tkst_pkg::queue_type q_in,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tkst_pkg::row_type   rsp_row
);

   localparam int SCORE_W = (SCORE_BITS < tkst_pkg::SCORE_PORT_BITS) ?
                            SCORE_BITS : tkst_pkg::SCORE_PORT_BITS;
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic {ST_IDLE, ST_LIST} state_type;

   logic [SCORE_W-1:0]                       score_ff   [TABLE_ENTRIES];
   logic [tkst_pkg::NAME_LOW_BITS-1:0]       name_lo_ff [TABLE_ENTRIES];
   logic [tkst_pkg::NAME_HIGH_BITS-1:0]      name_hi_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]                 new_ff;
   logic [CNT_W-1:0]                         count_ff;
   logic                                     acc_ff;
   logic [IDX_W-1:0]                         row_ff;
   state_type                                state_ff;
   logic                                     rsp_valid_ff;
   tkst_pkg::row_type                        rsp_row_ff;

   logic [SCORE_W-1:0]                       new_score;
   logic [TABLE_ENTRIES-1:0]                 keep, prev_keep, take, shift;
   logic                                     accept_new;
   logic                                     out_free;
   logic                                     row_last;
   tkst_pkg::row_type                        row_in;

   assign new_score = q_in.item.score[SCORE_W-1:0];

   // per-slot decision: keep, take the new entry, or take the slot above
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         keep[i] = (CNT_W'(i) < count_ff) && (score_ff[i] >= new_score);
      end
      prev_keep[0] = 1'b1;
      for (int i = 1; i < TABLE_ENTRIES; i++) begin
         prev_keep[i] = keep[i-1];
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         take[i]  = !keep[i] && prev_keep[i];
         shift[i] = !keep[i] && !prev_keep[i];
      end
   end

   // a full table whose lowest slot stays drops the submit
   assign accept_new = !keep[TABLE_ENTRIES-1];
   assign q_pop      = (state_ff == ST_IDLE) && q_in.valid;

   // table storage
   always_ff @(posedge clock) begin
      if (q_pop && accept_new) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (take[i]) begin
               score_ff[i]   <= new_score;
               name_lo_ff[i] <= q_in.item.name_low;
               name_hi_ff[i] <= q_in.item.name_high;
            end
         end
         for (int i = 1; i < TABLE_ENTRIES; i++) begin
            if (shift[i]) begin
               score_ff[i]   <= score_ff[i-1];
               name_lo_ff[i] <= name_lo_ff[i-1];
               name_hi_ff[i] <= name_hi_ff[i-1];
            end
         end
      end
   end

   // next listing row
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign row_last = ((CNT_W'(row_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      row_in.rank            = tkst_pkg::RANK_BITS'(row_ff);
      row_in.entry_score     = tkst_pkg::SCORE_PORT_BITS'(score_ff[row_ff]);
      row_in.entry_name_low  = name_lo_ff[row_ff];
      row_in.entry_name_high = name_hi_ff[row_ff];
      row_in.accepted        = acc_ff;
      row_in.is_new          = new_ff[row_ff];
      row_in.last            = row_last;
   end

   // sequencer with the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         acc_ff       <= 1'b0;
         new_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  if (count_ff != CNT_W'(TABLE_ENTRIES)) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  acc_ff   <= accept_new;
                  new_ff   <= accept_new ? take : '0;
                  row_ff   <= '0;
                  state_ff <= ST_LIST;
               end
            end
            ST_LIST: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= row_in;
                  if (row_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff <= row_ff + IDX_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = rsp_row_ff;

endmodule

/* rtl/core/top_k_score_table.sv */
// top-k score table: a submit beat passes the queue entry, the table update
// and the output register before its first row beat
// the back end takes no new submit until its listing is done; the single
// output register lists one table row per cycle while the result channel is ready
// reset empties the queue and sets the entry count to zero; table slots are
// left as they are and are only read once written
module top_k_score_table #(
   parameter int TABLE_ENTRIES = 5,
   parameter int SCORE_BITS    = 16
) (
   input logic         clock,
   input logic         reset,
   tkst_req_if.sink    req_chan,
   tkst_rsp_if.source  rsp_chan
);

   tkst_pkg::queue_type q_head;
   logic                q_pop;
   tkst_pkg::row_type   row;

   // submit queue
   tkst_front #(
      .SCORE_BITS (SCORE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_out    (q_head),
      .q_pop    (q_pop)
   );

   // table and listing
   tkst_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .SCORE_BITS    (SCORE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_row   (row)
   );

   // row beat onto the result channel
   assign rsp_chan.rank            = row.rank;
   assign rsp_chan.entry_score     = row.entry_score;
   assign rsp_chan.entry_name_low  = row.entry_name_low;
   assign rsp_chan.entry_name_high = row.entry_name_high;
   assign rsp_chan.accepted        = row.accepted;
   assign rsp_chan.is_new          = row.is_new;
   assign rsp_chan.last            = row.last;

endmodule

/* rtl/core/tkst_checker.sv */
// port-level checks on the listing channel, bound to the top level
module tkst_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [tkst_pkg::RANK_BITS-1:0]       rsp_rank,
   input logic [tkst_pkg::SCORE_PORT_BITS-1:0] rsp_score,
   input logic [tkst_pkg::NAME_LOW_BITS-1:0]   rsp_name_low,
   input logic [tkst_pkg::NAME_HIGH_BITS-1:0]  rsp_name_high,
   input logic                                 rsp_accepted,
   input logic                                 rsp_is_new,
   input logic                                 rsp_last
);

   logic [tkst_pkg::RANK_BITS-1:0] exp_rank_ff;
   logic                           seen_new_ff;
   logic                           rsp_beat;

   assign rsp_beat = rsp_valid && rsp_ready;

   // expected rank and new-row tracking per listing
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_rank_ff <= '0;
         seen_new_ff <= 1'b0;
      end else if (rsp_beat) begin
         exp_rank_ff <= rsp_last ? '0 : exp_rank_ff + 1'b1;
         seen_new_ff <= rsp_last ? 1'b0 : (seen_new_ff || rsp_is_new);
      end
   end

   // a stalled row beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rank) && $stable(rsp_score)
         && $stable(rsp_name_low) && $stable(rsp_name_high) && $stable(rsp_last))
      else $error("row beat changed while stalled");

   // rows come in rank order, starting from zero after each last row
   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rank == exp_rank_ff)
      else $error("row rank out of order");

   // the new row only appears when the submit was taken
   a_new_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_new |-> rsp_accepted)
      else $error("new row flagged on a dropped submit");

   // at most one new row per listing
   a_one_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_new |-> !seen_new_ff)
      else $error("second new row in one listing");

endmodule

bind top_k_score_table tkst_checker u_tkst_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_rank      (rsp_chan.rank),
   .rsp_score     (rsp_chan.entry_score),
   .rsp_name_low  (rsp_chan.entry_name_low),
   .rsp_name_high (rsp_chan.entry_name_high),
   .rsp_accepted  (rsp_chan.accepted),
   .rsp_is_new    (rsp_chan.is_new),
   .rsp_last      (rsp_chan.last)
);
